[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL of the colour converter.
// Every macro samples on the rising edge of clock.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that is ignored while reset is high.
`define RYUV_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that also holds during reset.
`define RYUV_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

[rtl/core/ryuv_pkg.sv]
// Package of the RGB to YUV 4:2:0 converter: types, coefficients, default sizes.
// No dependencies; used by the interfaces and all modules.
`timescale 1ns / 1ps

package ryuv_pkg;

   // Default frame limits
   localparam int DEF_MAX_WIDTH  = 4096;
   localparam int DEF_MAX_HEIGHT = 4096;

   // Register widths and indexes
   localparam int PAIRS_W = 12;
   localparam int ROWS_W  = 13;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DATA_W = 13;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam csr_idx_type CSR_LINE_PAIRS = csr_idx_type'(0);
   localparam csr_idx_type CSR_FRAME_ROWS = csr_idx_type'(1);

   localparam logic [PAIRS_W-1:0] LINE_PAIRS_RESET = 12'd320;
   localparam logic [ROWS_W-1:0]  FRAME_ROWS_RESET = 13'd480;

   // Fixed-point coefficients, scaled by 4096
   localparam logic [11:0] K_Y_R = 12'd1224;
   localparam logic [11:0] K_Y_G = 12'd2404;
   localparam logic [11:0] K_Y_B = 12'd467;
   localparam logic [11:0] K_U_R = 12'd602;
   localparam logic [11:0] K_U_G = 12'd1183;
   localparam logic [11:0] K_U_B = 12'd1785;
   localparam logic [11:0] K_V_R = 12'd2519;
   localparam logic [11:0] K_V_G = 12'd2109;
   localparam logic [11:0] K_V_B = 12'd409;
   localparam logic signed [10:0] CHROMA_OFFSET = 11'sd128;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [7:0] luma0;
      logic [7:0] luma1;
      logic [7:0] chroma_u;
      logic [7:0] chroma_v;
   } yuv_type;

   // Position flags that travel with an item
   typedef struct packed {
      logic chroma_valid;
      logic end_of_frame;
   } pos_flags_type;

   // One channel times a coefficient, truncated by 12 bits.
   // The largest result is 255 * 2519 / 4096 = 156, so 8 bits suffice.
   function automatic logic [7:0] scale_term(input logic [7:0] x, input logic [11:0] k);
      logic [19:0] prod;
      prod = 20'(x) * 20'(k);
      return prod[19:12];
   endfunction

   // Clamp a signed value to 0..255.
   function automatic logic [7:0] clamp8(input logic signed [10:0] v);
      logic [7:0] res;
      if (v < 11'sd0) begin
         res = 8'd0;
      end else if (v > 11'sd255) begin
         res = 8'd255;
      end else begin
         res = v[7:0];
      end
      return res;
   endfunction

endpackage

[rtl/core/ryuv_ifs.sv]
// Handshake interfaces of the colour converter: pixel pairs, results, register writes.
// Depends on ryuv_pkg.
`timescale 1ns / 1ps

interface ryuv_req_if import ryuv_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [7:0] red0;
   logic [7:0] green0;
   logic [7:0] blue0;
   logic [7:0] red1;
   logic [7:0] green1;
   logic [7:0] blue1;

   modport source (output valid, red0, green0, blue0, red1, green1, blue1, input ready);
   modport sink   (input valid, red0, green0, blue0, red1, green1, blue1, output ready);
endinterface

interface ryuv_rsp_if import ryuv_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [7:0] luma0;
   logic [7:0] luma1;
   logic [7:0] chroma_u;
   logic [7:0] chroma_v;
   logic       chroma_valid;
   logic       end_of_frame;

   modport source (output valid, luma0, luma1, chroma_u, chroma_v, chroma_valid,
                   end_of_frame, input ready);
   modport sink   (input valid, luma0, luma1, chroma_u, chroma_v, chroma_valid,
                   end_of_frame, output ready);
endinterface

interface ryuv_csr_if import ryuv_pkg::*; ();
   logic                  valid;
   logic                  ready;
   csr_idx_type           index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/ryuv_convert.sv]
// Colour arithmetic for one pixel pair: two lumas and the U/V pair.
// Depends on ryuv_pkg.
`timescale 1ns / 1ps

module ryuv_convert
   import ryuv_pkg::*;
(
   input  pixel_type pix0,
   input  pixel_type pix1,
   input  logic      chroma_valid,
   output yuv_type   yuv
);

   logic [9:0]         y0_sum;
   logic [9:0]         y1_sum;
   logic signed [10:0] u_sum;
   logic signed [10:0] v_sum;

   // Luma: three separately truncated terms per pixel
   assign y0_sum = 10'(scale_term(pix0.red, K_Y_R)) + 10'(scale_term(pix0.green, K_Y_G))
                 + 10'(scale_term(pix0.blue, K_Y_B));
   assign y1_sum = 10'(scale_term(pix1.red, K_Y_R)) + 10'(scale_term(pix1.green, K_Y_G))
                 + 10'(scale_term(pix1.blue, K_Y_B));

   // U from the first pixel, V from the second, both offset to mid scale
   assign u_sum = $signed({3'b000, scale_term(pix0.blue, K_U_B)})
                - $signed({3'b000, scale_term(pix0.red, K_U_R)})
                - $signed({3'b000, scale_term(pix0.green, K_U_G)}) + CHROMA_OFFSET;
   assign v_sum = $signed({3'b000, scale_term(pix1.red, K_V_R)})
                - $signed({3'b000, scale_term(pix1.green, K_V_G)})
                - $signed({3'b000, scale_term(pix1.blue, K_V_B)}) + CHROMA_OFFSET;

   // Clamp, and blank chroma on the second row of a pair
   always_comb begin
      yuv.luma0    = (y0_sum > 10'd255) ? 8'd255 : y0_sum[7:0];
      yuv.luma1    = (y1_sum > 10'd255) ? 8'd255 : y1_sum[7:0];
      yuv.chroma_u = chroma_valid ? clamp8(u_sum) : 8'd0;
      yuv.chroma_v = chroma_valid ? clamp8(v_sum) : 8'd0;
   end

endmodule

[rtl/core/rgb_to_yuv420_interleaved.sv]
// An item accepted on req is held in the input register, then in the result register, before rsp offers it.
// Throughput: one pixel pair per cycle while rsp accepts results; the input register and the result
// register each advance whenever the stage after them is free or draining.
// Reset (synchronous, active high) empties both stages, zeroes the column and
// row counters and restores line_pairs to 320 and frame_rows to 480.
// Top level of the RGB to YUV 4:2:0 converter; uses ryuv_pkg, ryuv_ifs, ryuv_convert.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rgb_to_yuv420_interleaved
   import ryuv_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input logic            clock,
   input logic            reset,
   ryuv_req_if.sink       req_chan,
   ryuv_rsp_if.source     rsp_chan,
   ryuv_csr_if.sink       csr_chan
);

   localparam int HALF_W = MAX_WIDTH / 2;
   localparam int COL_W  = (HALF_W > 1) ? $clog2(HALF_W) : 1;
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam logic [13:0] PAIRS_LIM = 14'(HALF_W);
   localparam logic [13:0] ROWS_LIM  = 14'(MAX_HEIGHT);

   // Configuration registers
   logic [PAIRS_W-1:0] line_pairs_ff;
   logic [ROWS_W-1:0]  frame_rows_ff;

   // Position counters
   logic [COL_W-1:0] column_ff, column_in;
   logic [ROW_W-1:0] row_ff, row_in;

   // Input stage and result stage
   logic          s1_valid_ff;
   pixel_type     pix0_ff, pix1_ff;
   pos_flags_type s1_flags_ff, s1_flags_in;
   logic          rsp_valid_ff;
   yuv_type       yuv_ff, yuv_in;
   pos_flags_type rsp_flags_ff;

   logic        req_fire;
   logic        out_free;
   logic        s1_advance;
   logic [13:0] eff_pairs;
   logic [13:0] eff_rows;
   logic        row_end;
   logic        last_row;

   assign csr_chan.ready = 1'b1;

   // Register writes; indexes beyond the list are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         line_pairs_ff <= LINE_PAIRS_RESET;
         frame_rows_ff <= FRAME_ROWS_RESET;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_LINE_PAIRS: line_pairs_ff <= csr_chan.data[PAIRS_W-1:0];
            CSR_FRAME_ROWS: frame_rows_ff <= csr_chan.data[ROWS_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective frame size: at least one pair and two rows, rows made even, limited to what the counters can reach
   always_comb begin
      eff_pairs = 14'(line_pairs_ff);
      if (line_pairs_ff == '0) begin
         eff_pairs = 14'd1;
      end else if (eff_pairs > PAIRS_LIM) begin
         eff_pairs = PAIRS_LIM;
      end
      eff_rows = 14'(frame_rows_ff);
      if (eff_rows < 14'd2) begin
         eff_rows = 14'd2;
      end else if (eff_rows > ROWS_LIM) begin
         eff_rows = ROWS_LIM;
      end
      eff_rows[0] = 1'b0;
   end

   // A counter at or past its last position ends the row or frame
   assign row_end  = 14'(column_ff) >= (eff_pairs - 14'd1);
   assign last_row = 14'(row_ff) >= (eff_rows - 14'd1);

   always_comb begin
      s1_flags_in.chroma_valid = ~row_ff[0];
      s1_flags_in.end_of_frame = row_end & last_row;
      if (row_end) begin
         column_in = '0;
         row_in    = last_row ? '0 : row_ff + ROW_W'(1);
      end else begin
         column_in = column_ff + COL_W'(1);
         row_in    = row_ff;
      end
   end

   // Handshake: each stage moves on when the next one is empty or emptying
   assign out_free       = ~rsp_valid_ff | rsp_chan.ready;
   assign s1_advance     = s1_valid_ff & out_free;
   assign req_chan.ready = ~s1_valid_ff | out_free;
   assign req_fire       = req_chan.valid & req_chan.ready;

   ryuv_convert u_convert (
      .pix0         (pix0_ff),
      .pix1         (pix1_ff),
      .chroma_valid (s1_flags_ff.chroma_valid),
      .yuv          (yuv_in)
   );

   // Control state: counters and stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff    <= '0;
         row_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            column_ff <= column_in;
            row_ff    <= row_in;
         end
         if (req_chan.ready) begin
            s1_valid_ff <= req_chan.valid;
         end
         if (out_free) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         pix0_ff     <= '{red: req_chan.red0, green: req_chan.green0, blue: req_chan.blue0};
         pix1_ff     <= '{red: req_chan.red1, green: req_chan.green1, blue: req_chan.blue1};
         s1_flags_ff <= s1_flags_in;
      end
      if (s1_advance) begin
         yuv_ff       <= yuv_in;
         rsp_flags_ff <= s1_flags_ff;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.luma0        = yuv_ff.luma0;
   assign rsp_chan.luma1        = yuv_ff.luma1;
   assign rsp_chan.chroma_u     = yuv_ff.chroma_u;
   assign rsp_chan.chroma_v     = yuv_ff.chroma_v;
   assign rsp_chan.chroma_valid = rsp_flags_ff.chroma_valid;
   assign rsp_chan.end_of_frame = rsp_flags_ff.end_of_frame;

   // Checks on the counters and the pipeline stages
   `RYUV_ASSERT(a_chroma_blank,
      (rsp_valid_ff && !rsp_flags_ff.chroma_valid)
         |-> (yuv_ff.chroma_u == 8'd0 && yuv_ff.chroma_v == 8'd0),
      "chroma not blanked on second row")
   `RYUV_ASSERT(a_column_range, 32'(column_ff) <= HALF_W - 1,
      "column counter out of range")
   `RYUV_ASSERT(a_frame_wrap,
      (req_fire && s1_flags_in.end_of_frame) |=> (column_ff == '0 && row_ff == '0),
      "counters not cleared after frame end")
   `RYUV_ASSERT_ALWAYS(a_reset_empty,
      $past(reset) |-> (!s1_valid_ff && !rsp_valid_ff),
      "pipeline not empty after reset")

endmodule
